// ===== src/dcke_pkg.sv =====
// ----------------------------------------------------------------------------
// dcke_pkg
// Shared types, constants and codes for the debounced chord key encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dcke_pkg;

   // Debounce counter width and the width used to compare against the
   // 8-bit qualify count.
   localparam int COUNT_WIDTH   = 8;
   localparam int QUALIFY_WIDTH = 8;
   localparam int CMP_WIDTH     = (COUNT_WIDTH > QUALIFY_WIDTH) ? COUNT_WIDTH : QUALIFY_WIDTH;

   // Key lines: A is the strobe, B..E carry chord weights.
   localparam int LINE_COUNT = 5;
   localparam int LINE_A     = 0;
   localparam int LINE_B     = 1;
   localparam int LINE_C     = 2;
   localparam int LINE_D     = 3;
   localparam int LINE_E     = 4;

   localparam int WEIGHT_WIDTH = 4;
   localparam int SUM_WIDTH    = 8;
   localparam int CODE_WIDTH   = 5;

   localparam logic [WEIGHT_WIDTH-1:0] LINE_WEIGHT [LINE_COUNT] = '{
      WEIGHT_WIDTH'(0), WEIGHT_WIDTH'(4), WEIGHT_WIDTH'(2),
      WEIGHT_WIDTH'(1), WEIGHT_WIDTH'(8)
   };

   localparam logic [SUM_WIDTH-1:0]     SUM_MAX       = '1;
   localparam logic [SUM_WIDTH-1:0]     CHORD_MAX     = SUM_WIDTH'(15);
   localparam logic [QUALIFY_WIDTH-1:0] QUALIFY_RESET = QUALIFY_WIDTH'(3);

   // Result codes
   localparam logic [CODE_WIDTH-1:0] CODE_NONE       = CODE_WIDTH'(0);
   localparam logic [CODE_WIDTH-1:0] CODE_UNDEFINED  = CODE_WIDTH'(16);
   localparam logic [CODE_WIDTH-1:0] CODE_READ_ERROR = CODE_WIDTH'(17);

   // Qualified edge reported by one lane for the current transfer
   typedef struct packed {
      logic press;
      logic release_q;
   } lane_event_type;

endpackage

`default_nettype wire

// ===== src/debounced_chord_key_encoder.sv =====
// ----------------------------------------------------------------------------
// debounced_chord_key_encoder
// Five-line debounced chord keypad encoder with a one-register qualify count.
// ----------------------------------------------------------------------------
// One sample is taken per clock while req_stall is low and each transfer gives
// exactly one result. The five key lines are debounced by five lanes side by
// side in the cycle of the transfer; a merge stage updates the chord sum and
// forms the code, which is written into a two-entry output buffer. The result
// is registered and reaches rsp_ from the output entry. req_stall rises only
// when both buffer entries hold results, so the block sustains one item per
// cycle whenever the result side does not stall. csr_wr_en/csr_wr_data write
// the qualify count (reset value 3); write it only while no item is in flight.
`default_nettype none

module debounced_chord_key_encoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_wr_en,
   input  wire logic [dcke_pkg::QUALIFY_WIDTH-1:0]  csr_wr_data,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_key_a,
   input  wire logic                                req_key_b,
   input  wire logic                                req_key_c,
   input  wire logic                                req_key_d,
   input  wire logic                                req_key_e,
   input  wire logic                                req_read_fault,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [dcke_pkg::CODE_WIDTH-1:0]          rsp_chord_code
);

   logic [dcke_pkg::QUALIFY_WIDTH-1:0] qualify_ff;
   logic                               req_xfer, rsp_xfer, lane_enable;
   logic [dcke_pkg::LINE_COUNT-1:0]    levels;
   dcke_pkg::lane_event_type           lane_events [dcke_pkg::LINE_COUNT];
   logic [dcke_pkg::CODE_WIDTH-1:0]    new_code;

   logic                               out_valid_ff, out_valid_in;
   logic [dcke_pkg::CODE_WIDTH-1:0]    out_code_ff, out_code_in;
   logic                               skid_valid_ff, skid_valid_in;
   logic [dcke_pkg::CODE_WIDTH-1:0]    skid_code_ff, skid_code_in;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset)          qualify_ff <= dcke_pkg::QUALIFY_RESET;
      else if (csr_wr_en) qualify_ff <= csr_wr_data;
   end

   assign req_stall   = skid_valid_ff;
   assign req_xfer    = req_valid && !req_stall;
   assign rsp_xfer    = out_valid_ff && !rsp_stall;
   assign lane_enable = req_xfer && !req_read_fault;

   assign levels = {req_key_e, req_key_d, req_key_c, req_key_b, req_key_a};

   // Debounce lanes
   for (genvar g = 0; g < dcke_pkg::LINE_COUNT; g++) begin : g_lane
      dcke_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .enable        (lane_enable),
         .level         (levels[g]),
         .qualify_count (qualify_ff),
         .lane_event    (lane_events[g])
      );
   end

   // Merge stage
   dcke_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .enable      (lane_enable),
      .read_fault  (req_read_fault),
      .lane_events (lane_events),
      .chord_code  (new_code)
   );

   // Two-entry output buffer
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_code_in   = out_code_ff;
      skid_valid_in = skid_valid_ff;
      skid_code_in  = skid_code_ff;
      if (rsp_xfer) begin
         out_valid_in  = skid_valid_ff;
         out_code_in   = skid_code_ff;
         skid_valid_in = 1'b0;
      end
      if (req_xfer) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_code_in  = new_code;
         end else begin
            skid_valid_in = 1'b1;
            skid_code_in  = new_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_code_ff  <= out_code_in;
      skid_code_ff <= skid_code_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_chord_code = out_code_ff;

endmodule

`default_nettype wire

// ===== src/dcke_lane.sv =====
// ----------------------------------------------------------------------------
// dcke_lane
// Debounce core for one key line: saturating high and low counters and a
// status bit. Reports a qualified press or release for the current sample.
// ----------------------------------------------------------------------------
`default_nettype none

module dcke_lane (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                enable,
   input  wire logic                                level,
   input  wire logic [dcke_pkg::QUALIFY_WIDTH-1:0]  qualify_count,
   output dcke_pkg::lane_event_type                 lane_event
);

   localparam logic [dcke_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic                              status_ff, status_in;
   logic [dcke_pkg::COUNT_WIDTH-1:0]  high_ff, high_in;
   logic [dcke_pkg::COUNT_WIDTH-1:0]  low_ff, low_in;
   logic                              high_ge, low_ge;

   // Compare counters against the qualify count at a common width
   assign high_ge = dcke_pkg::CMP_WIDTH'(high_ff) >= dcke_pkg::CMP_WIDTH'(qualify_count);
   assign low_ge  = dcke_pkg::CMP_WIDTH'(low_ff)  >= dcke_pkg::CMP_WIDTH'(qualify_count);

   // Qualified edges
   always_comb begin
      lane_event.press     = enable &&  level && !status_ff && high_ge;
      lane_event.release_q = enable && !level &&  status_ff && low_ge;
   end

   // Next state
   always_comb begin
      status_in = status_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      if (lane_event.press) begin
         status_in = 1'b1;
         low_in    = '0;
      end else if (lane_event.release_q) begin
         status_in = 1'b0;
         high_in   = '0;
      end else if (enable && level) begin
         if (!high_ge && high_ff != COUNT_MAX) high_in = high_ff + 1'b1;
      end else if (enable) begin
         if (!low_ge && low_ff != COUNT_MAX) low_in = low_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= 1'b0;
         high_ff   <= '0;
         low_ff    <= '0;
      end else begin
         status_ff <= status_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/dcke_merge.sv =====
// ----------------------------------------------------------------------------
// dcke_merge
// Combines the lane events: adds chord weights to the saturating sum, forms the
// code on a qualified strobe press or read fault; clears the sum on release.
// ----------------------------------------------------------------------------
`default_nettype none

module dcke_merge (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                enable,
   input  wire logic                                read_fault,
   input  wire dcke_pkg::lane_event_type            lane_events [dcke_pkg::LINE_COUNT],
   output logic [dcke_pkg::CODE_WIDTH-1:0]          chord_code
);

   logic [dcke_pkg::SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [dcke_pkg::SUM_WIDTH-1:0] sum_added;
   logic [dcke_pkg::SUM_WIDTH:0]   sum_wide;
   logic [dcke_pkg::WEIGHT_WIDTH-1:0] weight_total;

   // Weights of the chord lines pressed this sample (distinct bits, OR is a sum)
   always_comb begin
      weight_total = '0;
      for (int i = dcke_pkg::LINE_B; i < dcke_pkg::LINE_COUNT; i++) begin
         if (lane_events[i].press) weight_total = weight_total | dcke_pkg::LINE_WEIGHT[i];
      end
   end

   // Saturating add; all weights are positive so one clamp suffices
   assign sum_wide  = {1'b0, sum_ff} + (dcke_pkg::SUM_WIDTH+1)'(weight_total);
   assign sum_added = sum_wide[dcke_pkg::SUM_WIDTH] ? dcke_pkg::SUM_MAX
                                                    : sum_wide[dcke_pkg::SUM_WIDTH-1:0];

   // Strobe handling
   always_comb begin
      sum_in     = sum_ff;
      chord_code = dcke_pkg::CODE_NONE;
      priority if (read_fault) begin
         chord_code = dcke_pkg::CODE_READ_ERROR;
      end else if (enable) begin
         sum_in = sum_added;
         if (lane_events[dcke_pkg::LINE_A].press) begin
            if (sum_added != '0 && sum_added <= dcke_pkg::CHORD_MAX)
               chord_code = dcke_pkg::CODE_WIDTH'(sum_added);
            else
               chord_code = dcke_pkg::CODE_UNDEFINED;
         end else if (lane_events[dcke_pkg::LINE_A].release_q) begin
            sum_in = '0;
         end
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) sum_ff <= '0;
      else       sum_ff <= sum_in;
   end

endmodule

`default_nettype wire

// ===== src/dcke_checker.sv =====
// ----------------------------------------------------------------------------
// dcke_checker
// Port-level checks for the debounced chord key encoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dcke_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic                                req_read_fault,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [dcke_pkg::CODE_WIDTH-1:0]     rsp_chord_code
);

   // A stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_chord_code))
      else $error("stalled result changed or dropped");

   // Codes stay in their defined range
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chord_code <= dcke_pkg::CODE_READ_ERROR)
      else $error("result code out of range");

   // An empty output side never stalls the request side
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // A read fault transfer into an empty block shows a read error next cycle
   a_fault_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && !req_stall && req_read_fault |=>
         rsp_valid && rsp_chord_code == dcke_pkg::CODE_READ_ERROR)
      else $error("read fault did not give a read error code");

endmodule

bind debounced_chord_key_encoder dcke_checker u_dcke_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_read_fault (req_read_fault),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_chord_code (rsp_chord_code)
);

`default_nettype wire

// ===== tb/dcke_chord_checker.sv =====
// ----------------------------------------------------------------------------
// dcke_chord_checker
// Watches the request, response and CSR ports of the chord key encoder,
// predicts each chord code and compares it against the response transfers.
// ----------------------------------------------------------------------------
module dcke_chord_checker
   import dcke_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [QUALIFY_WIDTH-1:0]  csr_wr_data,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_key_a,
   input  logic                      req_key_b,
   input  logic                      req_key_c,
   input  logic                      req_key_d,
   input  logic                      req_key_e,
   input  logic                      req_read_fault,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [CODE_WIDTH-1:0]     rsp_chord_code,
   output int                        mismatch_count,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_MAX = (1 << COUNT_WIDTH) - 1;

   // Shadow copy of the debounce state
   logic [QUALIFY_WIDTH-1:0] qualify_count;
   logic [LINE_COUNT-1:0]    line_status;
   logic [COUNT_WIDTH-1:0]   high_count [LINE_COUNT];
   logic [COUNT_WIDTH-1:0]   low_count  [LINE_COUNT];
   logic [SUM_WIDTH-1:0]     chord_sum;

   logic [CODE_WIDTH-1:0]    expected_codes [$];
   logic [CODE_WIDTH-1:0]    expected_code;
   int                       mismatches = 0;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   // One debounce step of a single line; returns the qualified edge
   function automatic lane_event_type debounce_lane(input int lane, input logic level);
      lane_event_type ev;
      int             qual;
      int             high_val;
      int             low_val;
      ev       = '0;
      qual     = int'(qualify_count);
      high_val = int'(high_count[lane]);
      low_val  = int'(low_count[lane]);
      if (level) begin
         if (!line_status[lane] && high_val >= qual) begin
            line_status[lane] = 1'b1;
            low_count[lane]   = '0;
            ev.press          = 1'b1;
         end else if (high_val < qual && high_val < COUNT_MAX) begin
            high_count[lane] = high_count[lane] + 1'b1;
         end
      end else begin
         if (line_status[lane] && low_val >= qual) begin
            line_status[lane] = 1'b0;
            high_count[lane]  = '0;
            ev.release_q      = 1'b1;
         end else if (low_val < qual && low_val < COUNT_MAX) begin
            low_count[lane] = low_count[lane] + 1'b1;
         end
      end
      return ev;
   endfunction

   // Full sample: weight lines first, strobe last
   function automatic logic [CODE_WIDTH-1:0] predict_chord(input logic [LINE_COUNT-1:0] levels,
                                                           input logic fault);
      lane_event_type        ev;
      int                    sum_next;
      logic [CODE_WIDTH-1:0] code;
      code = CODE_NONE;
      if (fault) return CODE_READ_ERROR;
      for (int lane = LINE_B; lane <= LINE_E; lane++) begin
         ev = debounce_lane(lane, levels[lane]);
         if (ev.press) begin
            sum_next  = int'(chord_sum) + int'(LINE_WEIGHT[lane]);
            chord_sum = (sum_next > int'(SUM_MAX)) ? SUM_MAX : SUM_WIDTH'(sum_next);
         end
      end
      ev = debounce_lane(LINE_A, levels[LINE_A]);
      if (ev.press) begin
         if (chord_sum >= SUM_WIDTH'(1) && chord_sum <= CHORD_MAX) code = CODE_WIDTH'(chord_sum);
         else code = CODE_UNDEFINED;
      end else if (ev.release_q) begin
         chord_sum = '0;
      end
      return code;
   endfunction

   // Response compare first: a response always belongs to an older request
   always @(posedge clock) begin
      if (reset) begin
         qualify_count = QUALIFY_RESET;
         line_status   = '0;
         chord_sum     = '0;
         for (int lane = 0; lane < LINE_COUNT; lane++) begin
            high_count[lane] = '0;
            low_count[lane]  = '0;
         end
         expected_codes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               mismatches++;
               $display("%0t: chord_code transfer with none expected, expected none, actual %0d",
                        $time, rsp_chord_code);
            end else begin
               expected_code = expected_codes.pop_front();
               if (rsp_chord_code !== expected_code) begin
                  mismatches++;
                  $display("%0t: chord_code mismatch, expected %0d, actual %0d",
                           $time, expected_code, rsp_chord_code);
               end
            end
         end
         if (csr_wr_en) qualify_count = csr_wr_data;
         if (req_valid && !req_stall) begin
            expected_codes.push_back(predict_chord({req_key_e, req_key_d, req_key_c,
                                                    req_key_b, req_key_a}, req_read_fault));
         end
      end
      mismatch_count <= mismatches;
      outstanding    <= expected_codes.size();
   end

endmodule

// ===== tb/tb_debounced_chord_key_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_debounced_chord_key_encoder
// Stimulus and verdict for the debounced chord key encoder: directed chords,
// faults and qualify extremes, then random chord sequences and noise under
// random idling on both channels, with a checker instance doing the compare.
// ----------------------------------------------------------------------------
module tb_debounced_chord_key_encoder;
   timeunit 1ns;
   timeprecision 1ps;
   import dcke_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_LIMIT  = 1000;

   logic                     clock;
   logic                     reset          = 1'b1;
   logic                     csr_wr_en      = 1'b0;
   logic [QUALIFY_WIDTH-1:0] csr_wr_data    = '0;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic                     req_key_a      = 1'b0;
   logic                     req_key_b      = 1'b0;
   logic                     req_key_c      = 1'b0;
   logic                     req_key_d      = 1'b0;
   logic                     req_key_e      = 1'b0;
   logic                     req_read_fault = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic [CODE_WIDTH-1:0]    rsp_chord_code;

   int mismatch_count;
   int outstanding;
   int samples_sent = 0;
   bit steady       = 1'b0;   // no idling on either side
   bit hold_request = 1'b0;   // ask the receiver for one long hold-off

   debounced_chord_key_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_a      (req_key_a),
      .req_key_b      (req_key_b),
      .req_key_c      (req_key_c),
      .req_key_d      (req_key_d),
      .req_key_e      (req_key_e),
      .req_read_fault (req_read_fault),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_chord_code (rsp_chord_code)
   );

   dcke_chord_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key_a      (req_key_a),
      .req_key_b      (req_key_b),
      .req_key_c      (req_key_c),
      .req_key_d      (req_key_d),
      .req_key_e      (req_key_e),
      .req_read_fault (req_read_fault),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_chord_code (rsp_chord_code),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [LINE_COUNT-1:0] keys(input logic a, input logic b, input logic c,
                                                  input logic d, input logic e);
      return {e, d, c, b, a};
   endfunction

   // One request transfer; valid stays high afterwards until the next call or drain
   task automatic send_sample(input logic [LINE_COUNT-1:0] levels, input logic fault);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_key_a      <= levels[LINE_A];
      req_key_b      <= levels[LINE_B];
      req_key_c      <= levels[LINE_C];
      req_key_d      <= levels[LINE_D];
      req_key_e      <= levels[LINE_E];
      req_read_fault <= fault;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   // Stop offering and wait for every pending result
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_qualify(input logic [QUALIFY_WIDTH-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_noise();
      send_sample(LINE_COUNT'($urandom_range(0, 31)), $urandom_range(0, 7) == 0);
   endtask

   // Chord held, then strobe pressed, then all released, with random read faults; optionally corrupted
   task automatic play_chord(input int qual, input bit broken);
      logic [LINE_COUNT-1:0] chord;
      logic [LINE_COUNT-1:0] lv;
      int                    n;
      chord = '0;
      chord[LINE_E:LINE_B] = 4'($urandom_range(0, 15));
      for (int stage = 0; stage < 3; stage++) begin
         n = qual + 1 + $urandom_range(0, 2);
         repeat (n) begin
            lv = (stage == 2) ? '0 : chord;
            if (stage == 1) lv[LINE_A] = 1'b1;
            if (broken && $urandom_range(0, 3) == 0) lv[$urandom_range(0, LINE_COUNT-1)] ^= 1'b1;
            send_sample(lv, $urandom_range(0, 19) == 0);
         end
      end
   endtask

   // Repeated presses with the strobe idle drive the sum into saturation
   task automatic play_overflow(input int qual);
      logic [LINE_COUNT-1:0] lv;
      for (int round = 0; round < 34; round++) begin
         lv = '0;
         lv[LINE_E:LINE_B] = 4'($urandom_range(0, 15));
         lv[LINE_E] = 1'b1;
         repeat (qual + 1) send_sample(lv, 1'b0);
         repeat (qual + 1) send_sample('0, 1'b0);
      end
      repeat (qual + 1) send_sample(keys(1'b1, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0);
      repeat (qual + 1) send_sample('0, 1'b0);
   endtask

   // Receiver: random stall before each transfer, one long hold on request
   initial begin
      int n;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         n = steady ? 0 : $urandom_range(0, 4);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Stimulus and verdict
   initial begin
      int q;
      int pick;
      int waited;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset qualify count of 3
      send_sample('0, 1'b0);
      send_sample('0, 1'b0);
      send_sample('1, 1'b1);                                    // read fault, all keys pressed
      repeat (4) send_sample(keys(1'b1, 1'b1, 1'b0, 1'b1, 1'b0), 1'b0);  // chord B+D, strobe
      repeat (4) send_sample('0, 1'b0);                         // release clears the sum

      // Zero qualify count: every level change qualifies at once
      write_qualify('0);
      send_sample('1, 1'b0);                                    // full chord 15
      send_sample('0, 1'b0);
      send_sample(keys(1'b1, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0);    // empty chord
      send_sample('0, 1'b0);
      send_sample(keys(1'b0, 1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
      send_sample('0, 1'b0);
      send_sample(keys(1'b0, 1'b0, 1'b0, 1'b0, 1'b1), 1'b0);    // sum past 15
      send_sample(keys(1'b1, 1'b0, 1'b0, 1'b0, 1'b1), 1'b0);
      send_sample('0, 1'b1);
      send_sample('0, 1'b0);

      // Largest qualify count: nothing qualifies in a short run
      write_qualify('1);
      repeat (4) send_sample('1, 1'b0);
      send_sample('0, 1'b0);

      // Receiver holds off while the sender keeps offering back to back
      write_qualify('0);
      steady = 1'b1;
      hold_request = 1'b1;
      repeat (30) send_noise();
      steady = 1'b0;
      drain_results();

      // Random phases
      samples_sent = 0;
      while (samples_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1:    q = 0;
            2:       q = 1;
            3, 4:    q = 2;
            5, 6:    q = 3;
            7:       q = $urandom_range(4, 8);
            8:       q = 255;
            default: q = $urandom_range(9, 12);
         endcase
         write_qualify(QUALIFY_WIDTH'(q));
         steady = ($urandom_range(0, 5) == 0);
         if (q == 255) begin
            repeat (40) send_noise();
         end else begin
            repeat ($urandom_range(4, 10)) begin
               pick = $urandom_range(0, 9);
               if (pick < 6) play_chord(q, 1'b0);
               else if (pick < 8) play_chord(q, 1'b1);
               else if (pick == 9 && q <= 1) play_overflow(q);
               else repeat (4) send_noise();
            end
         end
         steady = 1'b0;
      end

      // Wind down
      req_valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (outstanding != 0 && waited < DRAIN_LIMIT);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/dcke_pkg.sv
src/dcke_lane.sv
src/dcke_merge.sv
src/debounced_chord_key_encoder.sv
src/dcke_checker.sv
tb/dcke_chord_checker.sv
tb/tb_debounced_chord_key_encoder.sv
